@@ hdl/region_intensity_statistics_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the region statistics block
// Expect clk and arst_n in the scope of each use.
// ----------------------------------------------------------------------------
`ifndef REGION_INTENSITY_STATISTICS_TOP_ASSERT_SVH
`define REGION_INTENSITY_STATISTICS_TOP_ASSERT_SVH

// condition that holds at every edge out of reset
`define RIS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent that holds in the cycle after the antecedent
`define RIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ris_pkg.sv @@
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types, codes and defaults of the region statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ris_pkg;

	localparam int MAX_REGIONS_DEF = 1024;
	localparam int PIXEL_LIMIT_DEF = 16777216;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = 2;
	localparam logic [QAW:0] QUEUE_FULL = (QAW + 1)'(QUEUE_DEPTH);

	// request codes
	localparam logic [1:0] REQ_ACCUM = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// register indexes (byte address bit 2)
	localparam logic REG_REGION_LIMIT   = 1'b0;
	localparam logic REG_SIGNED_SAMPLES = 1'b1;
	localparam logic [10:0] REGION_LIMIT_RST = 11'd1024;

	typedef enum logic [1:0] {
		K_ACC   = 2'd0,
		K_READ  = 2'd1,
		K_ZERO  = 2'd2,
		K_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        idx;
		logic signed [16:0] v;
		logic [31:0]        vsq;
	} q_entry_t;

	typedef struct packed {
		logic [24:0]        count;
		logic signed [40:0] sum;
		logic [55:0]        sq;
		logic signed [16:0] mn;
		logic signed [16:0] mx;
		logic               ovf;
	} st_entry_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic               start;
		logic               do_sd;
		logic [24:0]        n;
		logic signed [40:0] sum;
		logic [55:0]        sq;
	} calc_req_t;

	typedef struct packed {
		logic               done;
		logic signed [24:0] mean;
		logic [23:0]        sd;
	} calc_rsp_t;

endpackage

@@ hdl/ris_if.sv @@
// ----------------------------------------------------------------------------
// ris_if
// Item and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ris_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] pixel_label;
	logic [15:0] sample_value;
	logic [9:0]  read_region;

	modport source (output valid, req_type, pixel_label, sample_value, read_region,
		input ready);
	modport sink (input valid, req_type, pixel_label, sample_value, read_region,
		output ready);
endinterface

interface ris_result_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] region_min;
	logic signed [16:0] region_max;
	logic signed [40:0] region_sum;
	logic [24:0]        region_pixels;
	logic signed [24:0] region_mean;
	logic [23:0]        region_stddev;
	logic               region_overflow;

	modport source (output valid, region_min, region_max, region_sum, region_pixels,
		region_mean, region_stddev, region_overflow, input ready);
	modport sink (input valid, region_min, region_max, region_sum, region_pixels,
		region_mean, region_stddev, region_overflow, output ready);
endinterface

@@ hdl/ris_front.sv @@
// ----------------------------------------------------------------------------
// ris_front
// Accepts items, drops ignored pixels, decodes samples and squares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ris_front #(
	parameter int MAX_REGIONS = ris_pkg::MAX_REGIONS_DEF,
	parameter int SAMPLE_BITS = ris_pkg::SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ris_item_if.sink           items,
	input  logic [10:0]        region_limit,
	input  logic               signed_samples,
	input  ris_pkg::back_stat_t bstat,
	output logic               push,
	output ris_pkg::q_entry_t  push_entry,
	input  logic               full
);

	localparam logic [16:0] MR17   = 17'(MAX_REGIONS);
	localparam logic [15:0] SMASK  = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [16:0] SRANGE = 17'(32'd1 << SAMPLE_BITS);

	logic               valid_s1;
	ris_pkg::kind_t     kind_s1;
	logic [15:0]        idx_s1;
	logic signed [16:0] v_s1;

	logic               keep;
	ris_pkg::kind_t     kind;
	logic [15:0]        idx;
	logic [15:0]        idx_acc;
	logic [16:0]        lim17;
	logic               acc_ok;
	logic [15:0]        raw;
	logic [16:0]        v;
	logic signed [33:0] sq_full;
	logic               accept;

	assign idx_acc = items.pixel_label - 16'd1;
	assign lim17   = ({6'b0, region_limit} > MR17) ? MR17 : {6'b0, region_limit};
	assign acc_ok  = (items.pixel_label != 16'd0) && ({1'b0, idx_acc} < lim17);
	assign raw     = items.sample_value & SMASK;
	assign v       = (signed_samples && raw[SAMPLE_BITS-1]) ? ({1'b0, raw} - SRANGE)
		: {1'b0, raw};

	always_comb begin
		keep = 1'b0;
		kind = ris_pkg::K_ACC;
		idx  = idx_acc;
		unique case (items.req_type)
			ris_pkg::REQ_ACCUM: begin
				keep = acc_ok;
			end
			ris_pkg::REQ_READ: begin
				keep = 1'b1;
				idx  = {6'b0, items.read_region};
				kind = ({7'b0, items.read_region} < MR17) ? ris_pkg::K_READ
					: ris_pkg::K_ZERO;
			end
			ris_pkg::REQ_CLEAR: begin
				keep = 1'b1;
				kind = ris_pkg::K_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push         = valid_s1 && !full;
	assign items.ready  = !bstat.clearing && (!valid_s1 || !full);
	assign accept       = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1  <= idx;
			v_s1    <= v;
		end
	end

	assign sq_full = v_s1 * v_s1;

	always_comb begin
		push_entry      = '0;
		push_entry.kind = kind_s1;
		push_entry.idx  = idx_s1;
		push_entry.v    = v_s1;
		push_entry.vsq  = sq_full[31:0];
	end

endmodule

@@ hdl/ris_queue.sv @@
// ----------------------------------------------------------------------------
// ris_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ris_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ris_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output ris_pkg::q_entry_t head,
	output logic              empty
);

	ris_pkg::q_entry_t          slot_q [ris_pkg::QUEUE_DEPTH];
	logic [ris_pkg::QAW-1:0]    wr_q;
	logic [ris_pkg::QAW-1:0]    rd_q;
	logic [ris_pkg::QAW:0]      cnt_q;

	assign full  = cnt_q == ris_pkg::QUEUE_FULL;
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

@@ hdl/ris_calc.sv @@
// ----------------------------------------------------------------------------
// ris_calc
// Mean and standard deviation by shift-add multiply, restoring divide and
// digit-by-digit square root, one step a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ris_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  ris_pkg::calc_req_t req,
	output ris_pkg::calc_rsp_t rsp
);

	typedef enum logic [7:0] {
		C_IDLE = 8'b0000_0001,
		C_MEAN = 8'b0000_0010,
		C_MULA = 8'b0000_0100,
		C_MULB = 8'b0000_1000,
		C_SUB  = 8'b0001_0000,
		C_DIVS = 8'b0010_0000,
		C_ROOT = 8'b0100_0000,
		C_DONE = 8'b1000_0000
	} calc_st_t;

	calc_st_t           st_q;
	logic [24:0]        n_q;
	logic               neg_q;
	logic [40:0]        mag_q;
	logic [55:0]        sq_q;
	logic               dosd_q;
	logic [6:0]         cnt_q;
	logic [127:0]       dv_q;
	logic [49:0]        rem_q;
	logic [49:0]        dsr_q;
	logic [127:0]       mc_q;
	logic [40:0]        mp_q;
	logic [127:0]       acc_q;
	logic [127:0]       a_q;
	logic [63:0]        x_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic signed [24:0] mean_q;
	logic [23:0]        sd_q;

	logic [40:0]  req_mag;
	logic [50:0]  rem_sh;
	logic         div_ge;
	logic [49:0]  rem_nx;
	logic [127:0] dv_nx;
	logic [127:0] acc_nx;
	logic [63:0]  root_t;
	logic         root_ge;
	logic [63:0]  x_nx;
	logic [63:0]  res_nx;
	logic [49:0]  nn1;

	assign req_mag = req.sum[40] ? (~req.sum + 41'd1) : req.sum;

	// restoring divide step
	assign rem_sh = {rem_q, dv_q[127]};
	assign div_ge = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = div_ge ? 50'(rem_sh - {1'b0, dsr_q}) : rem_sh[49:0];
	assign dv_nx  = {dv_q[126:0], div_ge};

	// shift-add multiply step
	assign acc_nx = mp_q[0] ? (acc_q + mc_q) : acc_q;

	// square root step
	assign root_t  = res_q + bit_q;
	assign root_ge = x_q >= root_t;
	assign x_nx    = root_ge ? (x_q - root_t) : x_q;
	assign res_nx  = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	assign nn1 = n_q * (n_q - 25'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			unique case (st_q)
				C_IDLE: if (req.start) st_q <= C_MEAN;
				C_MEAN: if (cnt_q == 7'd127) st_q <= dosd_q ? C_MULA : C_DONE;
				C_MULA: if (mp_q == '0) st_q <= C_MULB;
				C_MULB: if (mp_q == '0) st_q <= C_SUB;
				C_SUB:  st_q <= (a_q <= acc_q) ? C_DONE : C_DIVS;
				C_DIVS: if (cnt_q == 7'd127) st_q <= C_ROOT;
				C_ROOT: if (bit_q[0]) st_q <= C_DONE;
				C_DONE: st_q <= C_IDLE;
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			C_IDLE: begin
				if (req.start) begin
					n_q    <= req.n;
					neg_q  <= req.sum[40];
					mag_q  <= req_mag;
					sq_q   <= req.sq;
					dosd_q <= req.do_sd;
					dv_q   <= {79'b0, req_mag, 8'b0};
					dsr_q  <= {25'b0, req.n};
					rem_q  <= '0;
					cnt_q  <= '0;
					sd_q   <= '0;
				end
			end
			C_MEAN: begin
				dv_q  <= dv_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					mean_q <= neg_q ? (25'd0 - dv_nx[24:0]) : dv_nx[24:0];
					mc_q   <= {72'b0, sq_q};
					mp_q   <= {16'b0, n_q};
					acc_q  <= '0;
				end
			end
			C_MULA: begin
				if (mp_q == '0) begin
					a_q   <= acc_q;
					acc_q <= '0;
					mc_q  <= {87'b0, mag_q};
					mp_q  <= mag_q;
				end else begin
					acc_q <= acc_nx;
					mc_q  <= {mc_q[126:0], 1'b0};
					mp_q  <= mp_q >> 1;
				end
			end
			C_MULB: begin
				if (mp_q != '0) begin
					acc_q <= acc_nx;
					mc_q  <= {mc_q[126:0], 1'b0};
					mp_q  <= mp_q >> 1;
				end
			end
			C_SUB: begin
				dv_q  <= (a_q - acc_q) << 16;
				dsr_q <= nn1;
				rem_q <= '0;
				cnt_q <= '0;
			end
			C_DIVS: begin
				dv_q  <= dv_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					// saturate a quotient beyond 64 bits
					x_q   <= (dv_nx[127:64] != '0) ? '1 : dv_nx[63:0];
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			C_ROOT: begin
				x_q   <= x_nx;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					sd_q <= (res_nx > 64'hFF_FFFF) ? 24'hFF_FFFF : res_nx[23:0];
				end
			end
			C_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = st_q == C_DONE;
	assign rsp.mean = mean_q;
	assign rsp.sd   = sd_q;

endmodule

@@ hdl/ris_back.sv @@
// ----------------------------------------------------------------------------
// ris_back
// Region store with read-modify-write, clearing sweep and read results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ris_back #(
	parameter int MAX_REGIONS = ris_pkg::MAX_REGIONS_DEF,
	parameter int PIXEL_LIMIT = ris_pkg::PIXEL_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ris_pkg::q_entry_t   head,
	input  logic                empty,
	output logic                pop,
	output ris_pkg::back_stat_t bstat,
	output ris_pkg::calc_req_t  creq,
	input  ris_pkg::calc_rsp_t  crsp,
	ris_result_if.source        results
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam logic [IW-1:0] LAST = IW'(MAX_REGIONS - 1);
	localparam logic [24:0] PLIM = 25'(PIXEL_LIMIT);

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_ACT   = 5'b00100,
		B_CALC  = 5'b01000,
		B_OUT   = 5'b10000
	} back_st_t;

	back_st_t           st_q;
	logic [IW-1:0]      clr_q;
	ris_pkg::q_entry_t  cur_q;
	ris_pkg::st_entry_t rd_q;
	ris_pkg::st_entry_t mem [MAX_REGIONS];

	logic signed [16:0] min_q;
	logic signed [16:0] max_q;
	logic signed [40:0] sum_q;
	logic [24:0]        pix_q;
	logic signed [24:0] mean_q;
	logic [23:0]        sd_q;
	logic               ovf_q;

	logic               re;
	logic               we;
	logic [IW-1:0]      wa;
	ris_pkg::st_entry_t wd;
	ris_pkg::st_entry_t upd;
	logic               is_read;

	assign pop     = (st_q == B_IDLE) && !empty;
	assign re      = pop && ((head.kind == ris_pkg::K_ACC) || (head.kind == ris_pkg::K_READ));
	assign is_read = cur_q.kind == ris_pkg::K_READ;
	assign bstat.clearing = st_q == B_CLEAR;

	// accumulate one pixel into the fetched entry, or flag overflow at the pixel limit
	always_comb begin
		upd = rd_q;
		if (rd_q.count >= PLIM) begin
			upd.ovf = 1'b1;
		end else begin
			upd.sum   = rd_q.sum + {{24{cur_q.v[16]}}, cur_q.v};
			upd.sq    = rd_q.sq + {24'b0, cur_q.vsq};
			upd.count = rd_q.count + 25'd1;
			if (rd_q.count == '0 || $signed(cur_q.v) < $signed(rd_q.mn)) begin
				upd.mn = cur_q.v;
			end
			if (rd_q.count == '0 || $signed(cur_q.v) > $signed(rd_q.mx)) begin
				upd.mx = cur_q.v;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		if (st_q == B_CLEAR) begin
			we = 1'b1;
		end else if (st_q == B_ACT && !is_read) begin
			we = 1'b1;
			wa = cur_q.idx[IW-1:0];
			wd = upd;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[head.idx[IW-1:0]];
		end
	end

	always_comb begin
		creq       = '0;
		creq.start = (st_q == B_ACT) && is_read && (rd_q.count != '0);
		creq.do_sd = rd_q.count > 25'd1;
		creq.n     = rd_q.count;
		creq.sum   = rd_q.sum;
		creq.sq    = rd_q.sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						st_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							ris_pkg::K_ACC, ris_pkg::K_READ: st_q <= B_ACT;
							ris_pkg::K_ZERO: st_q <= B_OUT;
							ris_pkg::K_CLEAR: begin
								clr_q <= '0;
								st_q  <= B_CLEAR;
							end
							default: st_q <= B_IDLE;
						endcase
					end
				end
				B_ACT: begin
					if (!is_read) begin
						st_q <= B_IDLE;
					end else begin
						st_q <= (rd_q.count == '0) ? B_OUT : B_CALC;
					end
				end
				B_CALC: if (crsp.done) st_q <= B_OUT;
				B_OUT:  if (results.ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			// read outside the store
			min_q  <= '0;
			max_q  <= '0;
			sum_q  <= '0;
			pix_q  <= '0;
			mean_q <= '0;
			sd_q   <= '0;
			ovf_q  <= 1'b0;
		end else if (st_q == B_ACT && is_read) begin
			sum_q <= rd_q.sum;
			pix_q <= rd_q.count;
			ovf_q <= rd_q.ovf;
			if (rd_q.count != '0) begin
				min_q <= rd_q.mn;
				max_q <= rd_q.mx;
			end
		end else if (st_q == B_CALC && crsp.done) begin
			mean_q <= crsp.mean;
			sd_q   <= crsp.sd;
		end
	end

	assign results.valid           = st_q == B_OUT;
	assign results.region_min      = min_q;
	assign results.region_max      = max_q;
	assign results.region_sum      = sum_q;
	assign results.region_pixels   = pix_q;
	assign results.region_mean     = mean_q;
	assign results.region_stddev   = sd_q;
	assign results.region_overflow = ovf_q;

endmodule

@@ hdl/region_intensity_statistics_top.sv @@
// ----------------------------------------------------------------------------
// region_intensity_statistics_top
// Accumulate: one front stage, then the back reads the store entry and writes it back.
// Read: the result waits on the one-bit-a-cycle divide, multiply and root.
// Reset and clear sweep the store, with no item taken meanwhile.
// Registers reset to region_limit 1024 and unsigned samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "region_intensity_statistics_top_assert.svh"

module region_intensity_statistics_top #(
	parameter int MAX_REGIONS = ris_pkg::MAX_REGIONS_DEF,
	parameter int PIXEL_LIMIT = ris_pkg::PIXEL_LIMIT_DEF,
	parameter int SAMPLE_BITS = ris_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ris_item_if.sink    items,
	ris_result_if.source results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0]         limit_q;
	logic                signed_q;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_empty;
	ris_pkg::q_entry_t   push_entry;
	ris_pkg::q_entry_t   head;
	ris_pkg::back_stat_t bstat;
	ris_pkg::calc_req_t  creq;
	ris_pkg::calc_rsp_t  crsp;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= ris_pkg::REGION_LIMIT_RST;
			signed_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == ris_pkg::REG_REGION_LIMIT) begin
				limit_q <= pwdata[10:0];
			end else begin
				signed_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == ris_pkg::REG_SIGNED_SAMPLES) ? {31'b0, signed_q}
		: {21'b0, limit_q};

	ris_front #(
		.MAX_REGIONS(MAX_REGIONS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.items          (items),
		.region_limit   (limit_q),
		.signed_samples (signed_q),
		.bstat          (bstat),
		.push           (q_push),
		.push_entry     (push_entry),
		.full           (q_full)
	);

	ris_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.empty      (q_empty)
	);

	ris_back #(
		.MAX_REGIONS(MAX_REGIONS),
		.PIXEL_LIMIT(PIXEL_LIMIT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (q_empty),
		.pop     (q_pop),
		.bstat   (bstat),
		.creq    (creq),
		.crsp    (crsp),
		.results (results)
	);

	ris_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	`RIS_ASSERT_ALWAYS(a_no_push_full, !(q_push && q_full), "transfer into a full queue")
	`RIS_ASSERT_ALWAYS(a_no_pop_empty, !(q_pop && q_empty), "pop from an empty queue")
	`RIS_ASSERT_ALWAYS(a_hold_clear, !(bstat.clearing && items.ready), "item taken during sweep")
	`RIS_ASSERT_NEXT(a_calc_busy, creq.start, !crsp.done, "calculation finished too early")

endmodule
